>>> hdl/rdmf_pkg.sv
package rdmf_pkg;

    localparam int COORD_W     = 16;
    localparam int ENTRY_W     = 4 * COORD_W;
    localparam int SQ_W        = 2 * COORD_W;
    localparam int IN_TDATA_W  = ENTRY_W;
    localparam int OUT_TDATA_W = 8;

    // Bit positions of the result flags in the output word.
    localparam int OUT_KEEP_BIT = 0;
    localparam int OUT_FULL_BIT = 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    // Status from the distance compare pipeline back to the controller.
    typedef struct packed {
        logic valid;
        logic hit;
        logic busy;
    } t_cmp_res;

endpackage

>>> hdl/rdmf_ram.sv
module rdmf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/rdmf_cmp.sv
module rdmf_cmp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [rdmf_pkg::ENTRY_W-1:0] i_entry,
    input  logic [rdmf_pkg::ENTRY_W-1:0] i_query,
    input  logic [rdmf_pkg::SQ_W-1:0]    i_rsq,
    output rdmf_pkg::t_cmp_res           o_res
);

    localparam int CW = rdmf_pkg::COORD_W;
    localparam int SW = rdmf_pkg::SQ_W;

    logic [CW-1:0] n_diff [4];
    logic [CW-1:0] r_diff [4];
    logic [SW-1:0] r_sq   [4];
    logic [SW:0]   sum_first;
    logic [SW:0]   sum_second;
    logic          r_v1;
    logic          r_v2;
    logic          r_v3;
    logic          r_hit;

    // Absolute coordinate differences, one lane per coordinate.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if (i_query[k*CW +: CW] > i_entry[k*CW +: CW]) begin
                n_diff[k] = i_query[k*CW +: CW] - i_entry[k*CW +: CW];
            end else begin
                n_diff[k] = i_entry[k*CW +: CW] - i_query[k*CW +: CW];
            end
        end
    end

    assign sum_first  = {1'b0, r_sq[0]} + {1'b0, r_sq[1]};
    assign sum_second = {1'b0, r_sq[2]} + {1'b0, r_sq[3]};

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r_diff[k] <= n_diff[k];
            r_sq[k]   <= SW'(r_diff[k]) * SW'(r_diff[k]);
        end
        r_hit <= (sum_first <= {1'b0, i_rsq}) && (sum_second <= {1'b0, i_rsq});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign o_res.valid = r_v3;
    assign o_res.hit   = r_hit;
    assign o_res.busy  = r_v1 | r_v2 | r_v3;

endmodule

>>> hdl/radius_duplicate_match_filter_unit.sv
// Radius duplicate filter for point correspondences.
//
// Input words arrive on s_axis: tdata carries first_x, first_y, second_x and
// second_y (16-bit unsigned 12.4 each), tuser carries start_list, which
// empties the store of kept correspondences before that word is checked.
// One result word per input leaves on m_axis: bit 0 is keep, bit 1 is
// store_full. The radius register is written on the cfg channel, which is
// always ready; write it only while no word is in flight.
//
// Each word is compared against every stored entry, one entry per cycle
// through the single read port of the store RAM and a three-stage distance
// pipeline. With N stored entries (at most MAX_KEPT) up to N reads are made;
// the scan stops early on a match. With a radius of zero the scan is skipped
// and the word goes straight to the done state. One word is processed at a
// time; the next one is accepted in the cycle after the result is loaded into
// the output register. If the receiver stalls, the result is held and the
// next word is scanned but waits before its result is loaded.
// Reset empties the store and clears the radius to zero.
module radius_duplicate_match_filter_unit #(
    parameter int MAX_KEPT = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [rdmf_pkg::COORD_W-1:0]     i_cfg_data,     // radius
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // first_x, first_y, second_x, second_y
    input  logic [rdmf_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic [0:0]                       s_axis_tuser,   // start_list
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [rdmf_pkg::OUT_TDATA_W-1:0] m_axis_tdata    // keep, store_full
);

    localparam int CNT_W  = $clog2(MAX_KEPT + 1);
    localparam int ADDR_W = $clog2(MAX_KEPT);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_KEPT);

    rdmf_pkg::t_state             r_state, n_state;
    logic [CNT_W-1:0]             r_count, n_count;
    logic [CNT_W-1:0]             r_issue, n_issue;
    logic                         r_hit, n_hit;
    logic                         r_bypass, n_bypass;
    logic                         r_rd_valid, n_rd_valid;
    logic                         r_out_valid, n_out_valid;
    logic                         r_out_keep, n_out_keep;
    logic                         r_out_full, n_out_full;
    logic [rdmf_pkg::ENTRY_W-1:0] r_query, n_query;
    logic [rdmf_pkg::COORD_W-1:0] r_radius;
    logic [rdmf_pkg::SQ_W-1:0]    r_rsq;
    logic                         ram_we;
    logic [rdmf_pkg::ENTRY_W-1:0] ram_rdata;
    rdmf_pkg::t_cmp_res           cmp_res;
    logic                         keep_now;

    rdmf_ram #(
        .WIDTH (rdmf_pkg::ENTRY_W),
        .DEPTH (MAX_KEPT)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (r_query),
        .i_raddr (r_issue[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    rdmf_cmp u_cmp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_rd_valid),
        .i_entry (ram_rdata),
        .i_query (r_query),
        .i_rsq   (r_rsq),
        .o_res   (cmp_res)
    );

    assign keep_now = r_bypass | ~r_hit;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_issue     = r_issue;
        n_hit       = r_hit;
        n_bypass    = r_bypass;
        n_query     = r_query;
        n_rd_valid  = 1'b0;
        n_out_valid = r_out_valid & ~m_axis_tready;
        n_out_keep  = r_out_keep;
        n_out_full  = r_out_full;
        ram_we      = 1'b0;
        case (r_state)
            rdmf_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_query  = s_axis_tdata;
                    n_hit    = 1'b0;
                    n_issue  = '0;
                    n_bypass = (r_radius == '0);
                    if (s_axis_tuser[0]) begin
                        n_count = '0;
                    end
                    n_state = (r_radius == '0) ? rdmf_pkg::S_DONE : rdmf_pkg::S_SCAN;
                end
            end
            rdmf_pkg::S_SCAN: begin
                if (!r_hit && (r_issue < r_count)) begin
                    n_rd_valid = 1'b1;
                    n_issue    = r_issue + 1'b1;
                end
                if (cmp_res.valid && cmp_res.hit) begin
                    n_hit = 1'b1;
                end
                // Finish once all reads are out (or a match was seen) and the
                // compare pipeline has drained.
                if ((r_hit || (r_issue == r_count)) && !r_rd_valid && !cmp_res.busy) begin
                    n_state = rdmf_pkg::S_DONE;
                end
            end
            rdmf_pkg::S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_keep  = keep_now;
                    n_out_full  = keep_now && !r_bypass && (r_count == CNT_MAX);
                    if (keep_now && !r_bypass && (r_count < CNT_MAX)) begin
                        ram_we  = 1'b1;
                        n_count = r_count + 1'b1;
                    end
                    n_state = rdmf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rdmf_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rdmf_pkg::S_IDLE;
            r_count     <= '0;
            r_issue     <= '0;
            r_hit       <= 1'b0;
            r_bypass    <= 1'b0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_keep  <= 1'b0;
            r_out_full  <= 1'b0;
            r_radius    <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_issue     <= n_issue;
            r_hit       <= n_hit;
            r_bypass    <= n_bypass;
            r_rd_valid  <= n_rd_valid;
            r_out_valid <= n_out_valid;
            r_out_keep  <= n_out_keep;
            r_out_full  <= n_out_full;
            if (i_cfg_valid) begin
                r_radius <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_query <= n_query;
        r_rsq   <= rdmf_pkg::SQ_W'(r_radius) * rdmf_pkg::SQ_W'(r_radius);
    end

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == rdmf_pkg::S_IDLE);
    assign m_axis_tvalid = r_out_valid;

    always_comb begin
        m_axis_tdata                        = '0;
        m_axis_tdata[rdmf_pkg::OUT_KEEP_BIT] = r_out_keep;
        m_axis_tdata[rdmf_pkg::OUT_FULL_BIT] = r_out_full;
    end

endmodule

>>> hdl/rdmf_chk.sv
module rdmf_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [rdmf_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    // A full store only matters for a word that was kept.
    a_full_implies_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[rdmf_pkg::OUT_KEEP_BIT] ||
                           !m_axis_tdata[rdmf_pkg::OUT_FULL_BIT]))
        else $error("store_full set on a dropped word");

    // Only one word is in the filter at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while a word is still being filtered");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("output word changed while stalled");

endmodule

bind radius_duplicate_match_filter_unit rdmf_chk u_rdmf_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> sim/radius_duplicate_match_filter_unit_tb.sv
`timescale 1ns / 1ps

module radius_duplicate_match_filter_unit_tb;

    localparam int MAX_KEPT    = 1024;
    localparam int STALL_LIMIT = 4000;
    localparam int BUILD_LEN   = 120;

    typedef struct packed {
        logic [rdmf_pkg::COORD_W-1:0] fx;
        logic [rdmf_pkg::COORD_W-1:0] fy;
        logic [rdmf_pkg::COORD_W-1:0] sx;
        logic [rdmf_pkg::COORD_W-1:0] sy;
        logic                         start;
        logic                         calm;
    } t_corr;

    typedef struct packed {
        logic keep;
        logic full;
    } t_verdict;

    logic                             i_clk         = 1'b0;
    logic                             i_rst_n       = 1'b0;
    logic                             i_cfg_valid   = 1'b0;
    logic                             o_cfg_ready;
    logic [rdmf_pkg::COORD_W-1:0]     i_cfg_data    = '0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [rdmf_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [0:0]                       s_axis_tuser  = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [rdmf_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    t_corr                        corr_backlog[$];
    t_verdict                     verdict_due[$];
    t_corr                        kept_mirror[MAX_KEPT];
    int                           kept_total = 0;
    logic [rdmf_pkg::COORD_W-1:0] radius_now = '0;
    t_corr                        corr_on_bus;
    int                           send_gap   = 0;
    int                           recv_gap   = 0;
    logic                         recv_calm  = 1'b0;
    int                           fails      = 0;
    int                           stall_cycles = 0;

    radius_duplicate_match_filter_unit #(
        .MAX_KEPT(MAX_KEPT)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [32:0] sq_dist(input logic [rdmf_pkg::COORD_W-1:0] ax, ay,
                                            bx, by);
        logic [32:0] dx;
        logic [32:0] dy;
        dx = 33'((ax > bx) ? ax - bx : bx - ax);
        dy = 33'((ay > by) ? ay - by : by - ay);
        return dx * dx + dy * dy;
    endfunction

    // Decides keep and store_full for one correspondence and updates the mirror
    // of the kept store, in the same order the block handles its words.
    function automatic t_verdict judge_corr(input t_corr c);
        t_verdict    v;
        logic [32:0] r_sq;
        logic        dup;
        if (c.start)
            kept_total = 0;
        v.keep = 1'b1;
        v.full = 1'b0;
        if (radius_now == 0)
            return v;
        r_sq = 33'(radius_now) * 33'(radius_now);
        dup  = 1'b0;
        for (int i = 0; i < kept_total && !dup; i++) begin
            if (sq_dist(c.fx, c.fy, kept_mirror[i].fx, kept_mirror[i].fy) <= r_sq &&
                sq_dist(c.sx, c.sy, kept_mirror[i].sx, kept_mirror[i].sy) <= r_sq)
                dup = 1'b1;
        end
        if (dup) begin
            v.keep = 1'b0;
        end else if (kept_total < MAX_KEPT) begin
            kept_mirror[kept_total] = c;
            kept_total++;
        end else begin
            v.full = 1'b1;
        end
        return v;
    endfunction

    function automatic logic [rdmf_pkg::COORD_W-1:0] nudge(
        input logic [rdmf_pkg::COORD_W-1:0] v, input int span);
        int t;
        t = int'(v) - span + int'($urandom_range(0, 2 * span));
        if (t < 0)
            t = 0;
        if (t > 16'hFFFF)
            t = 16'hFFFF;
        return t[rdmf_pkg::COORD_W-1:0];
    endfunction

    function automatic logic [rdmf_pkg::COORD_W-1:0] rand_coord(input int lo, input int hi);
        return 16'($urandom_range(lo, hi));
    endfunction

    task automatic add_corr(input logic [rdmf_pkg::COORD_W-1:0] fx, fy, sx, sy,
                            input logic start, input logic calm = 1'b0);
        t_corr c;
        c.fx    = fx;
        c.fy    = fy;
        c.sx    = sx;
        c.sy    = sy;
        c.start = start;
        c.calm  = calm;
        corr_backlog.insert(corr_backlog.size(), c);
    endtask

    task automatic write_radius(input logic [rdmf_pkg::COORD_W-1:0] r);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= r;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        radius_now = r;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (corr_backlog.size() > 0 || s_axis_tvalid || verdict_due.size() > 0);
        repeat (4) @(negedge i_clk);
    endtask

    // Lists of random length: each starts fresh, and most later words sit near
    // an earlier word of the same list so that the duplicate test is exercised
    // on both sides of the radius.
    task automatic queue_lists(input int n_words, input logic calm);
        t_corr list_pts[$];
        t_corr c;
        int    span;
        int    left;
        span = (radius_now == 0) ? 32 : int'(radius_now) + int'(radius_now) / 2 + 1;
        left = 0;
        for (int i = 0; i < n_words; i++) begin
            if (left == 0) begin
                left = $urandom_range(1, 40);
                list_pts.delete();
            end
            left--;
            if (list_pts.size() > 0 && $urandom_range(0, 2) != 0) begin
                c    = list_pts[$urandom_range(0, list_pts.size() - 1)];
                c.fx = nudge(c.fx, span);
                c.fy = nudge(c.fy, span);
                c.sx = nudge(c.sx, span);
                c.sy = nudge(c.sy, span);
            end else begin
                c.fx = rand_coord(0, 16'hFFFF);
                c.fy = rand_coord(0, 16'hFFFF);
                c.sx = rand_coord(0, 16'hFFFF);
                c.sy = rand_coord(0, 16'hFFFF);
            end
            c.start = (list_pts.size() == 0) || ($urandom_range(0, 15) == 0);
            c.calm  = calm;
            if (c.start)
                list_pts.delete();
            list_pts.insert(list_pts.size(), c);
            corr_backlog.insert(corr_backlog.size(), c);
        end
    endtask

    // Input side: holds a word until it is taken, otherwise idles in bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                verdict_due.insert(verdict_due.size(), judge_corr(corr_on_bus));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (corr_backlog.size() > 0 && !corr_backlog[0].calm &&
                             $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(0, 9);
                    s_axis_tvalid <= 1'b0;
                end else if (corr_backlog.size() > 0) begin
                    corr_on_bus = corr_backlog.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {corr_on_bus.sy, corr_on_bus.sx,
                                      corr_on_bus.fy, corr_on_bus.fx};
                    s_axis_tuser  <= corr_on_bus.start;
                    recv_calm     <= corr_on_bus.calm;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output side: checks every result word and stalls in bursts.
    always @(posedge i_clk) begin
        t_verdict want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            recv_gap = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (verdict_due.size() == 0) begin
                    $error("result word with nothing expected, tdata %h", m_axis_tdata);
                    fails++;
                end else begin
                    want = verdict_due.pop_front();
                    if (m_axis_tdata[rdmf_pkg::OUT_KEEP_BIT] !== want.keep) begin
                        $error("keep: expected %0b, actual %0b",
                               want.keep, m_axis_tdata[rdmf_pkg::OUT_KEEP_BIT]);
                        fails++;
                    end
                    if (m_axis_tdata[rdmf_pkg::OUT_FULL_BIT] !== want.full) begin
                        $error("store_full: expected %0b, actual %0b",
                               want.full, m_axis_tdata[rdmf_pkg::OUT_FULL_BIT]);
                        fails++;
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_axis_tready <= 1'b0;
            end else if (!recv_calm && $urandom_range(0, 7) == 0) begin
                recv_gap = $urandom_range(0, 9);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("radius_duplicate_match_filter_unit test failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        t_corr twin;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // One pixel radius: exact hits, the radius boundary, one image only.
        write_radius(16'd16);
        add_corr(16'd100, 16'd100, 16'd200, 16'd200, 1'b1);
        add_corr(16'd100, 16'd100, 16'd200, 16'd200, 1'b0);
        add_corr(16'd116, 16'd100, 16'd200, 16'd200, 1'b0);
        add_corr(16'd117, 16'd100, 16'd200, 16'd200, 1'b0);
        add_corr(16'd100, 16'd100, 16'd216, 16'd200, 1'b0);
        add_corr(16'd100, 16'd100, 16'd300, 16'd200, 1'b0);
        add_corr(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        add_corr(16'hFFF0, 16'hFFFF, 16'hFFFF, 16'hFFF0, 1'b0);
        add_corr(16'd100, 16'd100, 16'd200, 16'd200, 1'b1);
        add_corr(16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
        wait_drained();

        // Zero radius keeps everything and leaves the store alone.
        write_radius(16'd0);
        add_corr(16'd100, 16'd100, 16'd200, 16'd200, 1'b0);
        add_corr(16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
        add_corr(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        wait_drained();

        // Widest radius: squared distances reach past 32 bits.
        write_radius(16'hFFFF);
        add_corr(16'd100, 16'd100, 16'd200, 16'd200, 1'b0);
        add_corr(16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
        add_corr(16'hFFFF, 16'd0, 16'd0, 16'd0, 1'b0);
        add_corr(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        add_corr(16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 1'b0);
        wait_drained();

        // Build a long store of spaced points, then check near and exact repeats.
        write_radius(16'd1);
        for (int i = 0; i < BUILD_LEN; i++) begin
            add_corr(16'(2 * i), rand_coord(0, 16'hFFFF), rand_coord(0, 16'hFFFF),
                     rand_coord(0, 16'hFFFF), i == 0);
            if (i == 5)
                twin = corr_backlog[$];
        end
        add_corr(16'd4000, 16'd7, 16'd7, 16'd7, 1'b0);
        add_corr(16'd4002, 16'd7, 16'd7, 16'd7, 1'b0);
        add_corr(twin.fx, twin.fy, twin.sx, twin.sy, 1'b0);
        add_corr(16'd4000, 16'd7, 16'd7, 16'd7, 1'b1);
        add_corr(16'd4000, 16'd7, 16'd7, 16'd7, 1'b0);
        wait_drained();

        write_radius(rand_coord(1, 255));
        queue_lists(75, 1'b0);
        wait_drained();
        write_radius(16'd0);
        queue_lists(75, 1'b0);
        wait_drained();
        write_radius(rand_coord(256, 4095));
        queue_lists(75, 1'b0);
        wait_drained();
        write_radius(16'hFFFF);
        queue_lists(75, 1'b0);
        wait_drained();
        write_radius(rand_coord(1, 16'hFFFF));
        queue_lists(75, 1'b0);
        wait_drained();
        write_radius(rand_coord(8, 64));
        queue_lists(75, 1'b1);
        wait_drained();

        repeat (20) @(negedge i_clk);
        if (fails == 0 && verdict_due.size() == 0) begin
            $display("radius_duplicate_match_filter_unit test passed");
        end else begin
            $display("radius_duplicate_match_filter_unit test failed");
        end
        $finish;
    end

endmodule

>>> radius_duplicate_match_filter_unit.f
hdl/rdmf_pkg.sv
hdl/rdmf_ram.sv
hdl/rdmf_cmp.sv
hdl/radius_duplicate_match_filter_unit.sv
hdl/rdmf_chk.sv
sim/radius_duplicate_match_filter_unit_tb.sv
